// File: rtl/core/dptf_pkg.sv
// ----------------------------------------------------------------------------
// dptf_pkg
// Shared types and framing characters for the debug packet transmit framer.
// ----------------------------------------------------------------------------
package dptf_pkg;

    // Framing characters of the remote serial protocol
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_ESC   = 8'h7D;  // '}'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] ESC_XOR  = 8'h20;

    // Entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One classified item, as handed from front to back
    typedef struct packed {
        logic       start;  // open a packet: send '$', clear the sum
        logic       has;    // item carries a payload byte
        logic       esc;    // payload byte goes out as '}' + byte ^ 0x20
        logic       last;   // close the packet: '#' and two hex digits
        logic [7:0] data;
    } t_cmd;

endpackage

// File: rtl/core/dptf_front.sv
// ----------------------------------------------------------------------------
// dptf_front
// Accepts input transactions, tracks the open packet and classifies each item.
// ----------------------------------------------------------------------------
module dptf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_escape_enable,
    input  logic               i_first_item,
    input  logic               i_last_item,
    input  logic               i_has_byte,
    input  logic               i_queue_ready,
    output logic               o_push,
    output dptf_pkg::t_cmd     o_cmd
);

    logic r_in_frame;
    logic n_in_frame;
    logic special;

    assign special = (i_data_byte == dptf_pkg::CH_HASH)  ||
                     (i_data_byte == dptf_pkg::CH_START) ||
                     (i_data_byte == dptf_pkg::CH_ESC)   ||
                     (i_data_byte == dptf_pkg::CH_STAR);

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

    always_comb begin
        o_cmd.start = i_first_item || !r_in_frame;
        o_cmd.has   = i_has_byte;
        o_cmd.esc   = i_escape_enable && special;
        o_cmd.last  = i_last_item;
        o_cmd.data  = i_data_byte;
        n_in_frame  = r_in_frame;
        if (o_push) begin
            n_in_frame = !i_last_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
        end
    end

endmodule

// File: rtl/core/dptf_queue.sv
// ----------------------------------------------------------------------------
// dptf_queue
// Small command FIFO that decouples the front from the byte sequencer.
// ----------------------------------------------------------------------------
module dptf_queue #(
    parameter int DEPTH = dptf_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dptf_pkg::t_cmd     i_cmd,
    output logic               o_ready,
    input  logic               i_pop,
    output logic               o_valid,
    output dptf_pkg::t_cmd     o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dptf_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/dptf_back.sv
// ----------------------------------------------------------------------------
// dptf_back
// Byte sequencer: expands each command into framed bytes and keeps the sum.
// ----------------------------------------------------------------------------
module dptf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  dptf_pkg::t_cmd     i_q_cmd,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ESC,
        S_DATA,
        S_HASH,
        S_HI,
        S_LO
    } t_step;

    t_step          r_step, n_step;
    dptf_pkg::t_cmd r_cmd, n_cmd;
    logic [7:0]     r_sum, n_sum;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_byte, n_out_byte;
    logic           r_out_last, n_out_last;
    logic           out_free;
    logic [7:0]     payload;
    t_step          nxt;

    function automatic t_step step_after(dptf_pkg::t_cmd cmd, t_step cur);
        t_step after_data;
        t_step after_start;
        t_step res;
        after_data  = cmd.last ? S_HASH : S_IDLE;
        after_start = cmd.has ? (cmd.esc ? S_ESC : S_DATA) : after_data;
        case (cur)
            S_IDLE:  res = cmd.start ? S_START : after_start;
            S_START: res = after_start;
            S_ESC:   res = S_DATA;
            S_DATA:  res = after_data;
            S_HASH:  res = S_HI;
            S_HI:    res = S_LO;
            S_LO:    res = S_IDLE;
            default: res = S_IDLE;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
    endfunction

    assign out_free   = !r_out_valid || i_m_tready;
    assign payload    = r_cmd.esc ? (r_cmd.data ^ dptf_pkg::ESC_XOR) : r_cmd.data;
    assign nxt        = step_after(r_cmd, r_step);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        n_step      = r_step;
        n_cmd       = r_cmd;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        if (r_step != S_IDLE) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_last  = (r_step == S_LO);
                case (r_step)
                    S_START: begin
                        n_out_byte = dptf_pkg::CH_START;
                        n_sum      = 8'h00;
                    end
                    S_ESC: begin
                        n_out_byte = dptf_pkg::CH_ESC;
                        n_sum      = r_sum + dptf_pkg::CH_ESC;
                    end
                    S_DATA: begin
                        n_out_byte = payload;
                        n_sum      = r_sum + payload;
                    end
                    S_HASH:  n_out_byte = dptf_pkg::CH_HASH;
                    S_HI:    n_out_byte = hex_digit(r_sum[7:4]);
                    S_LO:    n_out_byte = hex_digit(r_sum[3:0]);
                    default: n_out_byte = r_out_byte;
                endcase
                n_step = nxt;
                // chain straight into the next command on the last byte
                if (nxt == S_IDLE && i_q_valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_q_cmd;
                    n_step = step_after(i_q_cmd, S_IDLE);
                end
            end
        end else if (i_q_valid) begin
            o_pop  = 1'b1;
            n_cmd  = i_q_cmd;
            n_step = step_after(i_q_cmd, S_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_sum       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

// File: rtl/core/debug_packet_tx_framer.sv
// ----------------------------------------------------------------------------
// debug_packet_tx_framer
// Transmit framer for debugger remote serial protocol packets.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata          tuser                                  tlast
//  -------  ---  -------------  -------------------------------------  ------------
//  s_axis   in   [7:0] byte     [0] escape_en [1] first [2] has_byte   last_item
//  m_axis   out  [7:0] out_byte -                                      end_of_frame
//
//  The input side takes one transaction per cycle while the command queue
//  (QUEUE_DEPTH entries) has room; it does not wait on the output.
//  The output side sends one byte per cycle while m_axis_tready holds high;
//  an item yields 0 to 6 output bytes ('$', '}', byte, '#', two hex digits);
//  the byte sequencer in the back part sets the sustained rate.
//  A sequencer that has gone idle first loads the next command and only then
//  sends its bytes, and an item that yields no byte still costs such a load.
//  Reset (i_rst_n low, synchronous) empties the queue, closes any open packet
//  and drops a pending output byte. A stall on m_axis holds the output
//  register; the queue then fills and s_axis_tready drops.
//
module debug_packet_tx_framer #(
    parameter int QUEUE_DEPTH = dptf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [0] escape_enable, [1] first_item, [2] has_byte
    input  logic        s_axis_tlast,   // last_item

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // end_of_frame
);

    dptf_pkg::t_cmd front_cmd;
    dptf_pkg::t_cmd queue_cmd;
    logic           push;
    logic           queue_ready;
    logic           queue_valid;
    logic           pop;

    // Classify each accepted transaction: open a packet if needed, flag bytes
    // that need escaping.
    dptf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_data_byte     (s_axis_tdata),
        .i_escape_enable (s_axis_tuser[0]),
        .i_first_item    (s_axis_tuser[1]),
        .i_last_item     (s_axis_tlast),
        .i_has_byte      (s_axis_tuser[2]),
        .i_queue_ready   (queue_ready),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Hold classified commands so either side can stall on its own.
    dptf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (queue_ready),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // Expand commands into framed bytes; the checksum lives here because it
    // follows the bytes in the order they go out.
    dptf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (queue_valid),
        .i_q_cmd    (queue_cmd),
        .o_pop      (pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

// File: rtl/core/dptf_checker.sv
// ----------------------------------------------------------------------------
// dptf_checker
// Port-level checks on the framed output stream of the framer.
// ----------------------------------------------------------------------------
module dptf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast
);

    logic out_xfer;
    logic r_after_eof;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Track frame boundaries: the next byte after reset or after a frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_eof <= 1'b1;
        end else if (out_xfer) begin
            r_after_eof <= m_axis_tlast;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_frame_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_after_eof |-> m_axis_tdata == dptf_pkg::CH_START)
        else $error("frame does not open with start character");

    a_eof_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && m_axis_tlast |->
            (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
            (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h66))
        else $error("frame end is not a lowercase hex digit");

endmodule

bind debug_packet_tx_framer dptf_checker u_dptf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
